### sv/gbsp_pkg.sv
// Package for the grid shortest-path block: payload structs, state codes, constants.
// Used by grid_bfs_shortest_path.
package gbsp_pkg;

  localparam int MAX_DIM_DEF = 64;
  localparam int DIST_W      = 12;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [0:0] REG_ROWS = 1'b0;
  localparam logic [0:0] REG_COLS = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic       cell_open;
    logic [5:0] start_row;
    logic [5:0] start_col;
    logic [5:0] target_row;
    logic [5:0] target_col;
  } in_word_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              reachable;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SEED,
    ST_POP,
    ST_POPWAIT,
    ST_NBR_RD,
    ST_NBR_CHK,
    ST_DONE
  } state_t;

endpackage

### sv/gbsp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gbsp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/grid_bfs_shortest_path.sv
// Top level of the grid breadth-first shortest-path block.
// Depends on gbsp_pkg and gbsp_ram (open map, visited map, frontier queue).
//
//  channel | direction | handshake            | word
//  in      | input     | in_valid / in_ready  | gbsp_pkg::in_word_t
//  out     | output    | out_valid / out_ready| gbsp_pkg::out_word_t
//  cfg     | input     | APB psel/penable     | grid_rows, grid_cols
//
// A write word is taken straight from idle. A query whose start differs from its target
// clears the visited map, seeds the start cell, then passes through ST_POP and ST_POPWAIT
// per dequeued cell, ST_NBR_RD and ST_NBR_CHK per in-grid neighbor and ST_NBR_RD alone
// per off-grid neighbor; each visited-map read goes through the RAM's registered read port.
// After reset the open and visited maps are swept clear; no word is accepted then.
// The result sits in an output register; the next word waits until it is taken.
module grid_bfs_shortest_path (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gbsp_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gbsp_pkg::out_word_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int MAX_DIM = gbsp_pkg::MAX_DIM_DEF;
  localparam int CW    = $clog2(MAX_DIM);
  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int AW    = 2 * CW;
  localparam int QW    = AW + 1;
  localparam int DW    = $clog2(MAX_DIM + 1);

  // configuration
  logic [6:0] grid_rows, grid_cols;
  logic [DW-1:0] rows_c, cols_c;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= 7'd64;
      grid_cols <= 7'd64;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        gbsp_pkg::REG_ROWS: if (paddr[1:0] == 2'b00) grid_rows <= pwdata[6:0];
        gbsp_pkg::REG_COLS: if (paddr[1:0] == 2'b00) grid_cols <= pwdata[6:0];
        default: ;
      endcase
    end
  end
  assign prdata = (paddr == 3'd0) ? {25'd0, grid_rows} :
                  (paddr == 3'd4) ? {25'd0, grid_cols} : 32'd0;

  function automatic logic [DW-1:0] clampd(input logic [6:0] v);
    if (v == 7'd0) return DW'(1);
    if (32'(v) > MAX_DIM) return DW'(MAX_DIM);
    return DW'(v);
  endfunction
  assign rows_c = clampd(grid_rows);
  assign cols_c = clampd(grid_cols);

  // memories
  logic          om_we, om_wd, om_rd;
  logic [AW-1:0] om_wa, om_ra;
  logic          vm_we, vm_wd, vm_rd;
  logic [AW-1:0] vm_wa, vm_ra;
  logic          q_we;
  logic [AW-1:0] q_wa, q_ra, q_rd, q_wd;

  gbsp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_open (
    .clk, .we(om_we), .waddr(om_wa), .wdata(om_wd), .raddr(om_ra), .rdata(om_rd));
  gbsp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_vis (
    .clk, .we(vm_we), .waddr(vm_wa), .wdata(vm_wd), .raddr(vm_ra), .rdata(vm_rd));
  gbsp_ram #(.WIDTH(AW), .DEPTH(CELLS)) u_queue (
    .clk, .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

  // control registers
  gbsp_pkg::state_t state, state_next;
  logic                 boot;
  logic [QW-1:0]        sweep, sweep_next;
  logic [QW-1:0]        head, head_next, tail, tail_next, lvl_end, lvl_end_next;
  logic [gbsp_pkg::DIST_W-1:0] level, level_next;
  logic [CW-1:0]        cur_r, cur_r_next, cur_c, cur_c_next;
  logic [1:0]           dir, dir_next;
  logic [CW:0]          nb_r, nb_c;
  logic                 nb_ok;
  logic [5:0]           tr, tc, tr_next, tc_next, sr, sc, sr_next, sc_next;
  logic                 boot_next;
  gbsp_pkg::out_word_t  res, res_next;
  logic                 res_v, res_v_next;

  assign out_valid = res_v;
  assign out_data  = res;

  // neighbor in direction order up, down, left, right
  always_comb begin
    nb_r = {1'b0, cur_r};
    nb_c = {1'b0, cur_c};
    unique case (dir)
      2'd0: nb_r = {1'b0, cur_r} - 1'b1;
      2'd1: nb_r = {1'b0, cur_r} + 1'b1;
      2'd2: nb_c = {1'b0, cur_c} - 1'b1;
      default: nb_c = {1'b0, cur_c} + 1'b1;
    endcase
    // underflow wraps to all ones, which fails the bound compare
    nb_ok = (32'(nb_r) < 32'(rows_c)) && (32'(nb_c) < 32'(cols_c));
  end

  logic st_in_store, tg_in_store, st_active;
  assign st_in_store = (32'(sr) < MAX_DIM) && (32'(sc) < MAX_DIM);
  assign tg_in_store = (32'(tr) < MAX_DIM) && (32'(tc) < MAX_DIM);
  assign st_active   = st_in_store && (32'(sr) < 32'(rows_c)) && (32'(sc) < 32'(cols_c));

  always_comb begin
    state_next = state;
    boot_next = boot;
    sweep_next = sweep;
    head_next = head; tail_next = tail; lvl_end_next = lvl_end;
    level_next = level;
    cur_r_next = cur_r; cur_c_next = cur_c; dir_next = dir;
    tr_next = tr; tc_next = tc; sr_next = sr; sc_next = sc;
    res_next = res;
    res_v_next = res_v && !out_ready;
    in_ready = 1'b0;
    om_we = 1'b0; om_wa = sweep[AW-1:0]; om_wd = 1'b0;
    om_ra = {nb_r[CW-1:0], nb_c[CW-1:0]};
    vm_we = 1'b0; vm_wa = sweep[AW-1:0]; vm_wd = 1'b0;
    vm_ra = {nb_r[CW-1:0], nb_c[CW-1:0]};
    q_we = 1'b0; q_wa = tail[AW-1:0]; q_wd = {nb_r[CW-1:0], nb_c[CW-1:0]};
    q_ra = head[AW-1:0];
    unique case (state)
      gbsp_pkg::ST_IDLE: begin
        in_ready = !res_v || out_ready;
        if (in_valid && in_ready) begin
          if (in_data.opcode == gbsp_pkg::OP_WRITE) begin
            om_we = (32'(in_data.cell_row) < MAX_DIM) && (32'(in_data.cell_col) < MAX_DIM);
            om_wa = {in_data.cell_row[CW-1:0], in_data.cell_col[CW-1:0]};
            om_wd = in_data.cell_open;
          end else if (in_data.start_row == in_data.target_row &&
                       in_data.start_col == in_data.target_col) begin
            res_next = '{distance: '0, reachable: 1'b1};
            res_v_next = 1'b1;
          end else begin
            sr_next = in_data.start_row; sc_next = in_data.start_col;
            tr_next = in_data.target_row; tc_next = in_data.target_col;
            sweep_next = '0;
            state_next = gbsp_pkg::ST_CLEAR;
          end
        end
      end
      gbsp_pkg::ST_CLEAR: begin
        // sweep visited map (and open map after reset)
        vm_we = 1'b1;
        om_we = boot;
        sweep_next = sweep + 1'b1;
        if (32'(sweep) == CELLS - 1) begin
          boot_next = 1'b0;
          state_next = boot ? gbsp_pkg::ST_IDLE : gbsp_pkg::ST_SEED;
        end
      end
      gbsp_pkg::ST_SEED: begin
        head_next = '0; level_next = '0;
        if (st_active) begin
          vm_we = 1'b1; vm_wa = {sr[CW-1:0], sc[CW-1:0]}; vm_wd = 1'b1;
          q_we = 1'b1; q_wa = '0; q_wd = {sr[CW-1:0], sc[CW-1:0]};
          tail_next = QW'(1);
          lvl_end_next = '0;
          state_next = gbsp_pkg::ST_POP;
        end else begin
          res_next = '{distance: '0, reachable: 1'b0};
          state_next = gbsp_pkg::ST_DONE;
        end
      end
      gbsp_pkg::ST_POP: begin
        if (head == tail) begin
          res_next = '{distance: '0, reachable: 1'b0};
          state_next = gbsp_pkg::ST_DONE;
        end else begin
          if (head == lvl_end) begin
            lvl_end_next = tail;
            if (level != gbsp_pkg::DIST_MAX) level_next = level + 1'b1;
          end
          state_next = gbsp_pkg::ST_POPWAIT;
        end
      end
      gbsp_pkg::ST_POPWAIT: begin
        cur_r_next = q_rd[AW-1:CW];
        cur_c_next = q_rd[CW-1:0];
        head_next = head + 1'b1;
        dir_next = 2'd0;
        state_next = gbsp_pkg::ST_NBR_RD;
      end
      gbsp_pkg::ST_NBR_RD: begin
        // memories read the neighbor address this cycle
        if (nb_ok) begin
          state_next = gbsp_pkg::ST_NBR_CHK;
        end else if (dir == 2'd3) begin
          state_next = gbsp_pkg::ST_POP;
        end else begin
          dir_next = dir + 1'b1;
        end
      end
      gbsp_pkg::ST_NBR_CHK: begin
        state_next = (dir == 2'd3) ? gbsp_pkg::ST_POP : gbsp_pkg::ST_NBR_RD;
        dir_next = dir + 1'b1;
        if (!vm_rd && om_rd) begin
          if (tg_in_store && nb_r[CW-1:0] == tr[CW-1:0] && nb_c[CW-1:0] == tc[CW-1:0]) begin
            res_next = '{distance: level, reachable: 1'b1};
            state_next = gbsp_pkg::ST_DONE;
          end else begin
            vm_we = 1'b1; vm_wa = {nb_r[CW-1:0], nb_c[CW-1:0]}; vm_wd = 1'b1;
            q_we = 1'b1;
            tail_next = tail + 1'b1;
          end
        end
      end
      gbsp_pkg::ST_DONE: begin
        if (!res_v || out_ready) begin
          res_v_next = 1'b1;
          state_next = gbsp_pkg::ST_IDLE;
        end
      end
      default: state_next = gbsp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbsp_pkg::ST_CLEAR;
      boot  <= 1'b1;
      sweep <= '0;
      res_v <= 1'b0;
      head <= '0; tail <= '0; lvl_end <= '0; level <= '0;
    end else begin
      state <= state_next;
      boot  <= boot_next;
      sweep <= sweep_next;
      res_v <= res_v_next;
      head <= head_next; tail <= tail_next; lvl_end <= lvl_end_next; level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_r_next; cur_c <= cur_c_next; dir <= dir_next;
    tr <= tr_next; tc <= tc_next; sr <= sr_next; sc <= sc_next;
    res <= res_next;
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == gbsp_pkg::ST_IDLE) else $error("ready outside idle");
  a_head_le_tail: assert property (@(posedge clk) disable iff (rst)
    head <= tail) else $error("queue head passed tail");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");
  a_boot_clear: assert property (@(posedge clk) disable iff (rst)
    boot |-> state == gbsp_pkg::ST_CLEAR) else $error("accepted during reset sweep");

endmodule
